// ===== hw/rtl/psic_pkg.sv =====
// Package for the per-source intrusion counter: sizes, codes, state encoding
// and the types used by the cells and the top level. No dependencies.
`timescale 1ns / 1ps

package psic_pkg;

  localparam int SRC_ENTRIES   = 1024;
  localparam int PORTS_PER_SRC = 64;
  localparam int NUM_CELLS     = 16;

  // Sources are striped over the cells: slot = {row, cell}.
  localparam int SRC_PER_CELL = SRC_ENTRIES / NUM_CELLS;
  // Ports of one source are striped the same way: index = {row, cell}.
  localparam int PORT_ROWS    = PORTS_PER_SRC / NUM_CELLS;

  localparam int SLOT_W  = $clog2(SRC_ENTRIES);
  localparam int USED_W  = $clog2(SRC_ENTRIES + 1);
  localparam int LSRC_W  = $clog2(SRC_PER_CELL);
  localparam int CELL_W  = $clog2(NUM_CELLS);
  localparam int ROW_W   = $clog2(PORT_ROWS);
  localparam int PIDX_W  = $clog2(PORTS_PER_SRC);
  localparam int PCNT_W  = $clog2(PORTS_PER_SRC + 1);
  localparam int PADDR_W = SLOT_W + ROW_W;

  localparam logic [15:0] TOP_PORT  = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] SVC_SMTP = 3'd1;
  localparam logic [2:0] SVC_HTTP = 3'd2;
  localparam logic [2:0] SVC_DNS  = 3'd3;
  localparam logic [2:0] SVC_FTP  = 3'd4;

  localparam logic [2:0] CFG_BACKDOOR = 3'd0;
  localparam logic [2:0] CFG_FLOOD    = 3'd1;
  localparam logic [2:0] CFG_SCAN     = 3'd2;
  localparam logic [2:0] CFG_BYTES    = 3'd3;
  localparam logic [2:0] CFG_HIGHPORT = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SSCAN = 5'b00010,
    ST_CRD   = 5'b00100,
    ST_PSCAN = 5'b01000,
    ST_UPD   = 5'b10000
  } state_e;

  // Match flags that ripple along the row of cells.
  typedef struct packed {
    logic src;
    logic port;
  } chain_t;

  typedef struct packed {
    logic [15:0]       hp;
    logic [15:0]       tr;
    logic [PCNT_W-1:0] pcnt;
  } cnt_t;

endpackage

// ===== hw/rtl/psic_if.sv =====
// Item channels of the per-source intrusion counter: connection records in
// and detection results out. Depends on nothing.
`timescale 1ns / 1ps

interface psic_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_address;
  logic [15:0] dest_port;
  logic [2:0]  service_code;
  logic [31:0] bytes_sent;
  logic [31:0] bytes_received;
  modport source (output valid, src_address, dest_port, service_code, bytes_sent,
                  bytes_received, input ready);
  modport sink (input valid, src_address, dest_port, service_code, bytes_sent,
                bytes_received, output ready);
endinterface

interface psic_out_if;
  logic        valid;
  logic        ready;
  logic        backdoor_hit;
  logic        flood_hit;
  logic        scan_hit;
  logic [31:0] backdoor_total;
  logic [31:0] flood_total;
  logic [31:0] scan_total;
  logic        sources_full;
  logic        ports_full;
  modport source (output valid, backdoor_hit, flood_hit, scan_hit, backdoor_total,
                  flood_total, scan_total, sources_full, ports_full, input ready);
  modport sink (input valid, backdoor_hit, flood_hit, scan_hit, backdoor_total,
                flood_total, scan_total, sources_full, ports_full, output ready);
endinterface

// ===== hw/rtl/psic_cell.sv =====
// One cell of the search row: a stripe of the source table and of the port
// sets, with its compares and its link in the match chain. Uses psic_pkg.
`timescale 1ns / 1ps

module psic_cell (
  input  logic                          clk_i,
  input  logic                          src_we_i,
  input  logic [psic_pkg::LSRC_W-1:0]   src_waddr_i,
  input  logic [31:0]                   src_wdata_i,
  input  logic [psic_pkg::LSRC_W-1:0]   src_raddr_i,
  input  logic [31:0]                   key_addr_i,
  input  logic                          src_vld_i,
  input  logic                          port_we_i,
  input  logic [psic_pkg::PADDR_W-1:0]  port_waddr_i,
  input  logic [15:0]                   port_wdata_i,
  input  logic [psic_pkg::PADDR_W-1:0]  port_raddr_i,
  input  logic [15:0]                   key_port_i,
  input  logic                          port_vld_i,
  input  psic_pkg::chain_t              chain_i,
  output psic_pkg::chain_t              chain_o,
  output psic_pkg::chain_t              first_o
);

  logic [31:0] src_mem [psic_pkg::SRC_PER_CELL];
  logic [15:0] port_mem [psic_pkg::SRC_ENTRIES * psic_pkg::PORT_ROWS];
  logic [31:0] src_rdata_q;
  logic [15:0] port_rdata_q;
  psic_pkg::chain_t match;

  always_ff @(posedge clk_i) begin
    if (src_we_i) begin
      src_mem[src_waddr_i] <= src_wdata_i;
    end
    src_rdata_q <= src_mem[src_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (port_we_i) begin
      port_mem[port_waddr_i] <= port_wdata_i;
    end
    port_rdata_q <= port_mem[port_raddr_i];
  end

  assign match.src  = src_vld_i && (src_rdata_q == key_addr_i);
  assign match.port = port_vld_i && (port_rdata_q == key_port_i);

  // A cell is first when it matches and no cell to its left did.
  assign chain_o    = chain_i | match;
  assign first_o    = match & ~chain_i;

endmodule

// ===== hw/rtl/per_source_intrusion_counter.sv =====
// Top level of the per-source intrusion counter: control, count store,
// configuration and the row of psic_cell. Uses psic_pkg and psic_if.
`timescale 1ns / 1ps

// Usage: connection records enter on in_ch, one result item per record
// leaves on out_ch; both are valid/ready channels. Configuration registers
// are to be written through cfg_we_i / cfg_idx_i / cfg_data_i only while
// the block is idle; the block does not enforce this. An unknown index is
// ignored. One record at a time is processed. The source table is searched
// by all sixteen cells at once, one row of the table per cycle. The count of
// the source is then read and its port set searched the same way; a record
// whose source finds no free slot skips both and goes on to the update.
// The steps are accept, source search, count read, port search and update.
// Reset empties the source table and clears the totals and the limits go
// to their defaults; no clearing pass is needed. The result is held in an
// output register; a stalled receiver holds the next record in its update
// step until the result has been taken.
module per_source_intrusion_counter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  psic_in_if.sink      in_ch,
  psic_out_if.source   out_ch
);

  localparam int NC = psic_pkg::NUM_CELLS;

  psic_pkg::state_e state_q, state_d;

  logic [15:0] bd_lim_q, fl_lim_q, sc_lim_q, floor_q;
  logic [31:0] byte_lim_q;

  logic [31:0] addr_q, sent_q, recv_q;
  logic [15:0] port_q;
  logic [2:0]  svc_q;

  logic [psic_pkg::USED_W-1:0] used_q;
  logic [psic_pkg::SLOT_W-1:0] slot_q;
  logic [psic_pkg::LSRC_W-1:0] j_q, jd_q;
  logic [psic_pkg::ROW_W-1:0]  r_q, rd_q;
  logic cmpv_q, new_q, have_q, known_q;
  psic_pkg::cnt_t cnt_q, cnt_rdata_q;
  psic_pkg::cnt_t cnt_mem [psic_pkg::SRC_ENTRIES];
  logic [31:0] bd_tot_q, fl_tot_q, sc_tot_q;

  logic        out_valid_q;
  logic        o_bd_q, o_fl_q, o_sc_q, o_sf_q, o_pf_q;
  logic [31:0] o_bdt_q, o_flt_q, o_sct_q;

  psic_pkg::chain_t chain [NC+1];
  psic_pkg::chain_t first [NC];
  logic [NC-1:0] src_vld, port_vld;
  logic [psic_pkg::CELL_W-1:0] first_src;

  logic src_wr;
  logic port_wr;
  logic [psic_pkg::PCNT_W-1:0] n;
  logic [psic_pkg::USED_W-1:0] src_next_base;
  logic [psic_pkg::PCNT_W-1:0] port_next_base;
  logic src_end, port_end, load;

  // Update values for the current record.
  logic hp_cond, tr_cond, listed, bd_hit, fl_hit, sc_hit, pf;
  logic [15:0] hp_new, tr_new;
  logic [psic_pkg::PCNT_W-1:0] n_new;

  assign chain[0] = '0;

  for (genvar c = 0; c < NC; c++) begin : g_cell
    assign src_vld[c]  = cmpv_q && ({1'b0, jd_q, psic_pkg::CELL_W'(c)} < used_q);
    assign port_vld[c] = cmpv_q && ({1'b0, rd_q, psic_pkg::CELL_W'(c)} < cnt_q.pcnt);
    psic_cell u_cell (
      .clk_i        (clk_i),
      .src_we_i     (src_wr && (used_q[psic_pkg::CELL_W-1:0] == psic_pkg::CELL_W'(c))),
      .src_waddr_i  (used_q[psic_pkg::SLOT_W-1:psic_pkg::CELL_W]),
      .src_wdata_i  (addr_q),
      .src_raddr_i  (j_q),
      .key_addr_i   (addr_q),
      .src_vld_i    (src_vld[c] && (state_q == psic_pkg::ST_SSCAN)),
      .port_we_i    (port_wr && (n[psic_pkg::CELL_W-1:0] == psic_pkg::CELL_W'(c))),
      .port_waddr_i ({slot_q, n[psic_pkg::PIDX_W-1:psic_pkg::CELL_W]}),
      .port_wdata_i (port_q),
      .port_raddr_i ({slot_q, r_q}),
      .key_port_i   (port_q),
      .port_vld_i   (port_vld[c] && (state_q == psic_pkg::ST_PSCAN)),
      .chain_i      (chain[c]),
      .chain_o      (chain[c+1]),
      .first_o      (first[c])
    );
  end

  always_comb begin
    first_src = '0;
    for (int c = 0; c < NC; c++) begin
      if (first[c].src) begin
        first_src = first_src | psic_pkg::CELL_W'(c);
      end
    end
  end

  assign src_next_base  = {1'b0, jd_q, {psic_pkg::CELL_W{1'b0}}} + psic_pkg::USED_W'(NC);
  assign src_end        = src_next_base >= used_q;
  assign port_next_base = {1'b0, rd_q, {psic_pkg::CELL_W{1'b0}}} + psic_pkg::PCNT_W'(NC);
  assign port_end       = port_next_base >= cnt_q.pcnt;

  assign src_wr = (state_q == psic_pkg::ST_SSCAN) && cmpv_q && !chain[NC].src && src_end
                  && (used_q < psic_pkg::USED_W'(psic_pkg::SRC_ENTRIES));

  assign n      = cnt_q.pcnt;
  assign listed = (svc_q == psic_pkg::SVC_SMTP) || (svc_q == psic_pkg::SVC_HTTP) ||
                  (svc_q == psic_pkg::SVC_DNS) || (svc_q == psic_pkg::SVC_FTP);
  assign hp_cond = (port_q > floor_q) && (port_q != psic_pkg::TOP_PORT) && !listed;
  assign tr_cond = (sent_q > byte_lim_q) || (recv_q > byte_lim_q);
  assign hp_new  = (hp_cond && (cnt_q.hp != psic_pkg::COUNT_MAX)) ? cnt_q.hp + 16'd1
                                                                   : cnt_q.hp;
  assign tr_new  = (tr_cond && (cnt_q.tr != psic_pkg::COUNT_MAX)) ? cnt_q.tr + 16'd1
                                                                   : cnt_q.tr;
  assign bd_hit  = have_q && hp_cond && (hp_new > bd_lim_q);
  assign fl_hit  = have_q && tr_cond && (tr_new > fl_lim_q);
  assign pf      = have_q && !known_q &&
                   (n == psic_pkg::PCNT_W'(psic_pkg::PORTS_PER_SRC));
  assign n_new   = (have_q && !known_q && !pf) ? n + psic_pkg::PCNT_W'(1) : n;
  assign sc_hit  = have_q && !known_q && !pf && ({9'd0, n_new} > sc_lim_q);

  assign load    = (state_q == psic_pkg::ST_UPD) && (!out_valid_q || out_ch.ready);
  assign port_wr = load && have_q && !known_q && !pf;

  assign in_ch.ready = (state_q == psic_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psic_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_d = psic_pkg::ST_SSCAN;
        end
      end
      psic_pkg::ST_SSCAN: begin
        if (cmpv_q && chain[NC].src) begin
          state_d = psic_pkg::ST_CRD;
        end else if (cmpv_q && src_end) begin
          state_d = src_wr ? psic_pkg::ST_CRD : psic_pkg::ST_UPD;
        end
      end
      psic_pkg::ST_CRD: state_d = psic_pkg::ST_PSCAN;
      psic_pkg::ST_PSCAN: begin
        if (cmpv_q && (chain[NC].port || port_end)) begin
          state_d = psic_pkg::ST_UPD;
        end
      end
      psic_pkg::ST_UPD: begin
        if (load) begin
          state_d = psic_pkg::ST_IDLE;
        end
      end
      default: state_d = psic_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psic_pkg::ST_IDLE;
      used_q      <= '0;
      bd_tot_q    <= '0;
      fl_tot_q    <= '0;
      sc_tot_q    <= '0;
      out_valid_q <= 1'b0;
      cmpv_q      <= 1'b0;
      bd_lim_q    <= 16'd50;
      fl_lim_q    <= 16'd3;
      sc_lim_q    <= 16'd5;
      byte_lim_q  <= 32'd100000;
      floor_q     <= 16'd1024;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          psic_pkg::CFG_BACKDOOR: bd_lim_q   <= cfg_data_i[15:0];
          psic_pkg::CFG_FLOOD:    fl_lim_q   <= cfg_data_i[15:0];
          psic_pkg::CFG_SCAN:     sc_lim_q   <= cfg_data_i[15:0];
          psic_pkg::CFG_BYTES:    byte_lim_q <= cfg_data_i;
          psic_pkg::CFG_HIGHPORT: floor_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        psic_pkg::ST_IDLE:  cmpv_q <= 1'b0;
        psic_pkg::ST_SSCAN: cmpv_q <= !(state_d == psic_pkg::ST_CRD);
        psic_pkg::ST_CRD:   cmpv_q <= 1'b0;
        psic_pkg::ST_PSCAN: cmpv_q <= 1'b1;
        psic_pkg::ST_UPD:   cmpv_q <= 1'b0;
        default:            cmpv_q <= 1'b0;
      endcase
      if (src_wr) begin
        used_q <= used_q + psic_pkg::USED_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
        if (bd_hit && (bd_tot_q != psic_pkg::TOTAL_MAX)) bd_tot_q <= bd_tot_q + 32'd1;
        if (fl_hit && (fl_tot_q != psic_pkg::TOTAL_MAX)) fl_tot_q <= fl_tot_q + 32'd1;
        if (sc_hit && (sc_tot_q != psic_pkg::TOTAL_MAX)) sc_tot_q <= sc_tot_q + 32'd1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      addr_q <= in_ch.src_address;
      port_q <= in_ch.dest_port;
      svc_q  <= in_ch.service_code;
      sent_q <= in_ch.bytes_sent;
      recv_q <= in_ch.bytes_received;
      j_q    <= '0;
    end
    if (state_q == psic_pkg::ST_SSCAN) begin
      j_q  <= j_q + psic_pkg::LSRC_W'(1);
      jd_q <= j_q;
      if (cmpv_q && chain[NC].src) begin
        slot_q <= {jd_q, first_src};
        new_q  <= 1'b0;
        have_q <= 1'b1;
      end else if (cmpv_q && src_end) begin
        slot_q <= used_q[psic_pkg::SLOT_W-1:0];
        new_q  <= 1'b1;
        have_q <= src_wr;
        known_q <= 1'b1;
      end
    end
    if (state_q == psic_pkg::ST_CRD) begin
      r_q <= '0;
    end
    if (state_q == psic_pkg::ST_PSCAN) begin
      r_q  <= r_q + psic_pkg::ROW_W'(1);
      rd_q <= r_q;
      if (!cmpv_q) begin
        cnt_q <= new_q ? '0 : cnt_rdata_q;
      end else begin
        known_q <= chain[NC].port;
      end
    end
    cnt_rdata_q <= cnt_mem[slot_q];
    if (load && have_q) begin
      cnt_mem[slot_q] <= '{hp: hp_new, tr: tr_new, pcnt: n_new};
    end
    if (load) begin
      o_bd_q  <= bd_hit;
      o_fl_q  <= fl_hit;
      o_sc_q  <= sc_hit;
      o_sf_q  <= !have_q;
      o_pf_q  <= pf;
      o_bdt_q <= (bd_hit && (bd_tot_q != psic_pkg::TOTAL_MAX)) ? bd_tot_q + 32'd1 : bd_tot_q;
      o_flt_q <= (fl_hit && (fl_tot_q != psic_pkg::TOTAL_MAX)) ? fl_tot_q + 32'd1 : fl_tot_q;
      o_sct_q <= (sc_hit && (sc_tot_q != psic_pkg::TOTAL_MAX)) ? sc_tot_q + 32'd1 : sc_tot_q;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.backdoor_hit   = o_bd_q;
  assign out_ch.flood_hit      = o_fl_q;
  assign out_ch.scan_hit       = o_sc_q;
  assign out_ch.backdoor_total = o_bdt_q;
  assign out_ch.flood_total    = o_flt_q;
  assign out_ch.scan_total     = o_sct_q;
  assign out_ch.sources_full   = o_sf_q;
  assign out_ch.ports_full     = o_pf_q;

endmodule

// ===== hw/rtl/psic_checker.sv =====
// Port-level checks for the per-source intrusion counter and the bind that
// attaches them to the top level. Depends on per_source_intrusion_counter.
`timescale 1ns / 1ps

module psic_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        bd_hit_i,
  input logic        sc_hit_i,
  input logic        fl_hit_i,
  input logic [31:0] bd_total_i,
  input logic        src_full_i,
  input logic        prt_full_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bd_total_i))
    else $error("result dropped or changed under stall");

  a_hit_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bd_hit_i |-> bd_total_i != 32'd0)
    else $error("backdoor hit with zero total");

  a_full_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && src_full_i |-> !bd_hit_i && !fl_hit_i && !sc_hit_i && !prt_full_i)
    else $error("hit reported for a dropped source");

  a_pfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prt_full_i |-> !sc_hit_i)
    else $error("scan hit with full port set");

endmodule

bind per_source_intrusion_counter psic_port_checks u_psic_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .bd_hit_i    (out_ch.backdoor_hit),
  .sc_hit_i    (out_ch.scan_hit),
  .fl_hit_i    (out_ch.flood_hit),
  .bd_total_i  (out_ch.backdoor_total),
  .src_full_i  (out_ch.sources_full),
  .prt_full_i  (out_ch.ports_full)
);
